// File: hw/rtl/bdotmc_pkg.sv
// Shared types and constants for the b-dot magnetorquer command block.
// Used by every module under hw/rtl; depends on nothing else.
package bdotmc_pkg;

  localparam int NUM_AXES   = 3;
  localparam int MAG_W      = 16;  // magnetometer sample and dipole width
  localparam int DT_W       = 16;  // elapsed time width
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 15;
  localparam int NEEDLE_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd67200;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_Z = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_HOLD
  } top_st_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_ABS,
    MS_RUN,
    MS_CLAMP
  } mul_st_t;

  // Per-axis result handed from a multiplier lane to the output stage.
  typedef struct packed {
    logic               neg;   // dipole is positive when the error is negative
    logic               over;  // magnitude was clamped
    logic [LIMIT_W-1:0] mag;
  } axis_res_t;

endpackage

// File: hw/rtl/bdot_magnetorquer_command.sv
// Top level of the b-dot magnetorquer command block: registers, sequencer, output stage.
// Depends on bdotmc_pkg, bdotmc_div and bdotmc_mul.
//
// The block turns one three-axis magnetometer sample plus the elapsed time in
// milliseconds into a clamped dipole command per axis and a capped flag.
// Input requests arrive on in_valid/in_ready, results leave on out_valid/out_ready,
// and the gain, the dipole limit and the needle vector are written through the
// cfg_valid/cfg_ready port (cfg_index selects the register, cfg_data carries it).
// Configuration is always ready and should only be written while the block is idle.
// The three axes run side by side: each has a bit-serial divider that produces one
// quotient bit per cycle (16 + FRAC_BITS bits) and a multiplier that takes one gain
// bit per cycle (24 bits). The block accepts one request at a time; a new one is
// taken only after the previous result has moved to the output register.
// A finished result sits in the output register, so the next request is accepted
// while the receiver stalls; a second result then waits in the lanes until the
// output register frees up. Reset clears the handshakes, restores the register
// reset values and zeroes the stored previous sample.
module bdot_magnetorquer_command
  import bdotmc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [MAG_W-1:0] mag_x,
  input  logic signed [MAG_W-1:0] mag_y,
  input  logic signed [MAG_W-1:0] mag_z,
  input  logic [DT_W-1:0]        elapsed_ms,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [MAG_W-1:0] dipole_x,
  output logic signed [MAG_W-1:0] dipole_y,
  output logic signed [MAG_W-1:0] dipole_z,
  output logic                   capped,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int QW = MAG_W + FRAC_BITS;

  top_st_t state, state_next;

  logic [GAIN_W-1:0]   gain;
  logic [LIMIT_W-1:0]  dipole_limit;
  logic [NEEDLE_W-1:0] needle [NUM_AXES];
  logic [MAG_W-1:0]    prev   [NUM_AXES];
  logic [MAG_W-1:0]    mag_in [NUM_AXES];
  logic [MAG_W-1:0]    cmd    [NUM_AXES];
  logic                dneg   [NUM_AXES];
  logic [NUM_AXES-1:0] div_done;
  logic [NUM_AXES-1:0] mul_done;
  axis_res_t           res    [NUM_AXES];

  logic accept;
  logic load_out;

  assign mag_in[0] = mag_x;
  assign mag_in[1] = mag_y;
  assign mag_in[2] = mag_z;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain         <= GAIN_RESET;
      dipole_limit <= LIMIT_RESET;
      needle[0]    <= '0;
      needle[1]    <= '0;
      needle[2]    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN:     gain         <= cfg_data[GAIN_W-1:0];
        REG_LIMIT:    dipole_limit <= cfg_data[LIMIT_W-1:0];
        REG_NEEDLE_X: needle[0]    <= cfg_data[NEEDLE_W-1:0];
        REG_NEEDLE_Y: needle[1]    <= cfg_data[NEEDLE_W-1:0];
        REG_NEEDLE_Z: needle[2]    <= cfg_data[NEEDLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // One lane per axis. The field difference is formed at acceptance, its magnitude
  // goes to the divider and its sign is kept for the error stage.
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    logic [MAG_W:0] diff;
    logic [MAG_W:0] diff_abs;
    logic [QW-1:0]  quo;

    always_comb begin
      diff     = {mag_in[i][MAG_W-1], mag_in[i]} - {prev[i][MAG_W-1], prev[i]};
      diff_abs = diff[MAG_W] ? (~diff + 1'b1) : diff;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        prev[i] <= '0;
      end else if (accept) begin
        prev[i] <= mag_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        dneg[i] <= diff[MAG_W];
      end
    end

    bdotmc_div #(
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk  (clk),
      .rst  (rst),
      .start(accept),
      .dm   (diff_abs[MAG_W-1:0]),
      .dt   (elapsed_ms),
      .done (div_done[i]),
      .q    (quo)
    );

    bdotmc_mul #(
      .FRAC_BITS(FRAC_BITS)
    ) u_mul (
      .clk   (clk),
      .rst   (rst),
      .start (div_done[i]),
      .q     (quo),
      .q_neg (dneg[i]),
      .needle(needle[i]),
      .gain  (gain),
      .limit (dipole_limit),
      .done  (mul_done[i]),
      .res   (res[i])
    );

    // The dipole opposes the error, so a negative error gives a positive command.
    assign cmd[i] = res[i].neg ? {1'b0, res[i].mag} : (~{1'b0, res[i].mag} + 1'b1);
  end

  // Sequencer: all lanes run in lockstep, so the whole item advances together.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (&div_done) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (&mul_done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        // Wait here while the previous result is still stalled at the output.
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      dipole_x <= cmd[0];
      dipole_y <= cmd[1];
      dipole_z <= cmd[2];
      capped   <= res[0].over || res[1].over || res[2].over;
    end
  end

endmodule

// File: hw/rtl/bdotmc_div.sv
// Bit-serial restoring divider: (dm << FRAC_BITS) / dt, one quotient bit a cycle.
// Depends on bdotmc_pkg.
module bdotmc_div
  import bdotmc_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  localparam int QW = MAG_W + FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] dm,
  input  logic [DT_W-1:0]  dt,
  output logic             done,
  output logic [QW-1:0]    q
);

  localparam int CW = $clog2(QW);
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [DT_W-1:0] rem;
  logic [DT_W-1:0] dvs;
  logic [QW-1:0]   work;
  logic            dt_zero;

  logic [DT_W:0]   trial;
  logic [DT_W:0]   trial_sub;
  logic            ge;
  logic [DT_W-1:0] rem_next;

  // The partial remainder stays below a nonzero divisor, so one extra bit suffices.
  always_comb begin
    trial     = {rem, work[QW-1]};
    trial_sub = trial - {1'b0, dvs};
    ge        = (trial >= {1'b0, dvs});
    rem_next  = ge ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits shift out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      work    <= {dm, {FRAC_BITS{1'b0}}};
      rem     <= '0;
      dvs     <= dt;
      dt_zero <= (dt == '0);
    end else if (busy) begin
      rem  <= rem_next;
      work <= {work[QW-2:0], ge};
    end
  end

  // A zero elapsed time means a zero derivative.
  assign q = dt_zero ? '0 : work;

endmodule

// File: hw/rtl/bdotmc_mul.sv
// Error formation, gain-serial shift-add multiplier and clamp for one axis.
// Depends on bdotmc_pkg.
module bdotmc_mul
  import bdotmc_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  localparam int QW = MAG_W + FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [QW-1:0]       q,
  input  logic                q_neg,
  input  logic [NEEDLE_W-1:0] needle,
  input  logic [GAIN_W-1:0]   gain,
  input  logic [LIMIT_W-1:0]  limit,
  output logic                done,
  output axis_res_t           res
);

  localparam int DW = (MAG_W + 1 + FRAC_BITS > NEEDLE_W) ? MAG_W + 1 + FRAC_BITS : NEEDLE_W;
  localparam int EW = DW + 1;
  localparam int PW = EW + GAIN_W;
  localparam int GCW = $clog2(GAIN_W);
  localparam logic [GCW-1:0] GLAST = GCW'(GAIN_W - 1);

  mul_st_t state, state_next;

  logic [GCW-1:0]    cnt;
  logic [EW-1:0]     s;
  logic              qn;
  logic [EW-1:0]     em;
  logic              neg_err;
  logic [EW-1:0]     acc;
  logic [GAIN_W-1:0] low;
  logic [GAIN_W-1:0] g;

  logic [EW-1:0]     q_ext;
  logic [EW-1:0]     needle_ext;
  logic [EW:0]       sum;
  logic [PW-1:0]     product;
  logic              hi_any;
  logic [LIMIT_W-1:0] mid;
  logic              over;

  always_comb begin
    q_ext      = {{(EW - QW){1'b0}}, q};
    needle_ext = {{(EW - NEEDLE_W){needle[NEEDLE_W-1]}}, needle};
    sum        = {1'b0, acc} + (g[0] ? {1'b0, em} : '0);
    product    = {acc, low};
    hi_any     = |product[PW-1:FRAC_BITS+LIMIT_W];
    mid        = product[FRAC_BITS+LIMIT_W-1:FRAC_BITS];
    over       = hi_any || (mid > limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MS_CLAMP);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      MS_IDLE:  if (start) state_next = MS_ABS;
      MS_ABS:   state_next = MS_RUN;
      MS_RUN:   if (cnt == GLAST) state_next = MS_CLAMP;
      MS_CLAMP: state_next = MS_IDLE;
      default:  state_next = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MS_IDLE: begin
        // For a negative derivative, err = -(q + needle); the sign is folded in later.
        if (start) begin
          s  <= q_neg ? (q_ext + needle_ext) : (q_ext - needle_ext);
          qn <= q_neg;
        end
      end
      MS_ABS: begin
        em      <= s[EW-1] ? (~s + 1'b1) : s;
        neg_err <= (s != '0) && (s[EW-1] ^ qn);
        acc     <= '0;
        g       <= gain;
        cnt     <= '0;
      end
      MS_RUN: begin
        acc <= sum[EW:1];
        low <= {sum[0], low[GAIN_W-1:1]};
        g   <= g >> 1;
        cnt <= cnt + 1'b1;
      end
      MS_CLAMP: begin
        res.neg  <= neg_err;
        res.over <= over;
        res.mag  <= over ? limit : mid;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/bdotmc_checker.sv
// Port-level checker for the b-dot magnetorquer command block, with its bind.
// Depends on bdotmc_pkg; attaches to bdot_magnetorquer_command.
module bdotmc_checker
  import bdotmc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic signed [MAG_W-1:0] mag_x,
  input logic signed [MAG_W-1:0] mag_y,
  input logic signed [MAG_W-1:0] mag_z,
  input logic [DT_W-1:0]        elapsed_ms,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [MAG_W-1:0] dipole_x,
  input logic signed [MAG_W-1:0] dipole_y,
  input logic signed [MAG_W-1:0] dipole_z,
  input logic                   capped,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_IDX_W-1:0]   cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [LIMIT_W-1:0] lim;
  logic [MAG_W-1:0]   lim_w;
  logic [MAG_W-1:0]   ax;
  logic [MAG_W-1:0]   ay;
  logic [MAG_W-1:0]   az;

  // Shadow copy of the dipole limit as seen on the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_LIMIT) begin
      lim <= cfg_data[LIMIT_W-1:0];
    end
  end

  always_comb begin
    lim_w = {1'b0, lim};
    ax    = dipole_x[MAG_W-1] ? (~dipole_x + 1'b1) : dipole_x;
    ay    = dipole_y[MAG_W-1] ? (~dipole_y + 1'b1) : dipole_y;
    az    = dipole_z[MAG_W-1] ? (~dipole_z + 1'b1) : dipole_z;
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in progress");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dipole_x) && $stable(dipole_y)
      && $stable(dipole_z) && $stable(capped))
    else $error("stalled result changed");

  a_within_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ax <= lim_w && ay <= lim_w && az <= lim_w)
    else $error("dipole command exceeds the limit");

  a_capped_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && capped |-> ax == lim_w || ay == lim_w || az == lim_w)
    else $error("capped set but no axis sits at the limit");

endmodule

bind bdot_magnetorquer_command bdotmc_checker u_bdotmc_checker (.*);

// File: test/bdotmc_dipole_check.sv
// Checker for the b-dot magnetorquer command block: watches the request,
// result and configuration channels, predicts each dipole command and compares.
// Depends on bdotmc_pkg for widths, register indexes and reset values.
module bdotmc_dipole_check
  import bdotmc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [MAG_W-1:0] mag_x,
  input  logic signed [MAG_W-1:0] mag_y,
  input  logic signed [MAG_W-1:0] mag_z,
  input  logic [DT_W-1:0]         elapsed_ms,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [MAG_W-1:0] dipole_x,
  input  logic signed [MAG_W-1:0] dipole_y,
  input  logic signed [MAG_W-1:0] dipole_z,
  input  logic                    capped,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic signed [MAG_W-1:0] dx;
    logic signed [MAG_W-1:0] dy;
    logic signed [MAG_W-1:0] dz;
    logic                    cap;
  } dipole_cmd_t;

  dipole_cmd_t expected_cmds[$];
  dipole_cmd_t want_cmd;
  dipole_cmd_t next_cmd;

  logic [GAIN_W-1:0]          cur_gain;
  logic [LIMIT_W-1:0]         cur_limit;
  logic signed [NEEDLE_W-1:0] cur_needle[NUM_AXES];
  logic signed [MAG_W-1:0]    prev_field[NUM_AXES];
  logic                       hit_x, hit_y, hit_z;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // One axis of the controller: derivative, needle error, negated gain, clamp.
  function automatic logic signed [MAG_W-1:0] axis_dipole(
    input logic signed [MAG_W-1:0]    cur,
    input logic signed [MAG_W-1:0]    prev,
    input logic [DT_W-1:0]            dt,
    input logic signed [NEEDLE_W-1:0] ndl,
    input logic [GAIN_W-1:0]          k,
    input logic [LIMIT_W-1:0]         lim,
    output logic                      clamped
  );
    logic signed [63:0] diff;
    logic signed [63:0] deriv;
    logic signed [63:0] err;
    logic [63:0]        dmag;
    logic [63:0]        quo;
    logic [63:0]        emag;
    logic [127:0]       prod;
    logic [63:0]        mag;
    logic [MAG_W-1:0]   mag16;
    diff = $signed(cur) - $signed(prev);
    deriv = 0;
    if (dt != 0) begin
      dmag = (diff < 0) ? -diff : diff;
      quo = (dmag << FRAC_BITS) / dt;
      deriv = (diff < 0) ? -$signed(quo) : $signed(quo);
    end
    err = deriv - ndl;
    emag = (err < 0) ? -err : err;
    prod = emag * k;
    mag = prod[63+FRAC_BITS:FRAC_BITS];
    clamped = 1'b0;
    if (mag > lim) begin
      mag = lim;
      clamped = 1'b1;
    end
    mag16 = mag[MAG_W-1:0];
    return (err < 0) ? mag16 : -mag16;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_gain = GAIN_RESET;
      cur_limit = LIMIT_RESET;
      for (int a = 0; a < NUM_AXES; a++) begin
        cur_needle[a] = '0;
        prev_field[a] = '0;
      end
      expected_cmds.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("dipole command with no request outstanding");
        end else begin
          want_cmd = expected_cmds.pop_front();
          if (dipole_x !== want_cmd.dx)
            report_mismatch($sformatf("dipole_x got %0d want %0d", dipole_x, want_cmd.dx));
          if (dipole_y !== want_cmd.dy)
            report_mismatch($sformatf("dipole_y got %0d want %0d", dipole_y, want_cmd.dy));
          if (dipole_z !== want_cmd.dz)
            report_mismatch($sformatf("dipole_z got %0d want %0d", dipole_z, want_cmd.dz));
          if (capped !== want_cmd.cap)
            report_mismatch($sformatf("capped got %b want %b", capped, want_cmd.cap));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN:     cur_gain = cfg_data[GAIN_W-1:0];
          REG_LIMIT:    cur_limit = cfg_data[LIMIT_W-1:0];
          REG_NEEDLE_X: cur_needle[0] = cfg_data;
          REG_NEEDLE_Y: cur_needle[1] = cfg_data;
          REG_NEEDLE_Z: cur_needle[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        next_cmd.dx = axis_dipole(mag_x, prev_field[0], elapsed_ms, cur_needle[0],
                                  cur_gain, cur_limit, hit_x);
        next_cmd.dy = axis_dipole(mag_y, prev_field[1], elapsed_ms, cur_needle[1],
                                  cur_gain, cur_limit, hit_y);
        next_cmd.dz = axis_dipole(mag_z, prev_field[2], elapsed_ms, cur_needle[2],
                                  cur_gain, cur_limit, hit_z);
        next_cmd.cap = hit_x | hit_y | hit_z;
        expected_cmds.push_back(next_cmd);
        prev_field[0] = mag_x;
        prev_field[1] = mag_y;
        prev_field[2] = mag_z;
      end
    end
    pending = expected_cmds.size();
  end

endmodule

// File: test/tb_top.sv
// Top of the testbench for the b-dot magnetorquer command block: clock, reset,
// request and configuration stimulus, receiver back-pressure and the verdict.
// Depends on bdotmc_pkg, bdot_magnetorquer_command and bdotmc_dipole_check.
module tb_top;
  import bdotmc_pkg::*;

  // Bound on the run of some 1350 requests; even with both sides idling hard
  // it leaves a wide margin.
  localparam int CYCLE_LIMIT = 800000;
  // Extra cycles run after the block has gone idle, before the verdict.
  localparam int SETTLE_CYCLES = 120;
  // A gain of one in fixed point, so with a zero derivative the dipole magnitude equals the needle.
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 24'd1 << 16;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 148;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [MAG_W-1:0] mag_x;
  logic signed [MAG_W-1:0] mag_y;
  logic signed [MAG_W-1:0] mag_z;
  logic [DT_W-1:0]         elapsed_ms;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [MAG_W-1:0] dipole_x;
  logic signed [MAG_W-1:0] dipole_y;
  logic signed [MAG_W-1:0] dipole_z;
  logic                    capped;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  int fail_count;
  int pending;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;

  // Last sample handed to the block, used to make small field changes.
  logic signed [MAG_W-1:0] last_sent[NUM_AXES];

  bdot_magnetorquer_command #(.FRAC_BITS(16)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .dipole_x(dipole_x), .dipole_y(dipole_y), .dipole_z(dipole_z), .capped(capped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bdotmc_dipole_check #(.FRAC_BITS(16)) u_dipole_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .dipole_x(dipole_x), .dipole_y(dipole_y), .dipole_z(dipole_z), .capped(capped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Free-running clock with a period of 8.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog: if the run hangs, end it with the failure verdict.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver. It accepts results at random according to recv_idle_pct, and when
  // the stimulus asks for a hold-off it keeps out_ready low for that many cycles,
  // counting them down here, so the block fills up and pushes back on requests.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else if (rst) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request and waits until the block takes it. Idle cycles come
  // before the request; valid is only lowered in a cycle of its own, so a
  // back-to-back request keeps valid high across the boundary.
  task automatic send_item(input int x, input int y, input int z, input int dt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mag_x      <= MAG_W'(x);
    mag_y      <= MAG_W'(y);
    mag_z      <= MAG_W'(z);
    elapsed_ms <= DT_W'(dt);
    last_sent[0] = MAG_W'(x);
    last_sent[1] = MAG_W'(y);
    last_sent[2] = MAG_W'(z);
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering requests and waits until every predicted result has been
  // taken, plus a few cycles, so that configuration sees an idle block. The
  // first edge lets the checker count a request taken at the edge just passed.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write; valid drops in the accepting step and the task then
  // waits with valid low, so the next write raises it in a later step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [GAIN_W-1:0] k, input logic [LIMIT_W-1:0] lim,
                           input int nx, input int ny, input int nz);
    cfg_write(REG_GAIN, CFG_DATA_W'(k));
    cfg_write(REG_LIMIT, CFG_DATA_W'(lim));
    cfg_write(REG_NEEDLE_X, CFG_DATA_W'(nx));
    cfg_write(REG_NEEDLE_Y, CFG_DATA_W'(ny));
    cfg_write(REG_NEEDLE_Z, CFG_DATA_W'(nz));
  endtask

  function automatic int pick_needle();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  // Random settings for one phase, with the extremes of each register mixed in.
  // Small gains and needles are favored so that many commands stay unclamped.
  task automatic random_config();
    logic [GAIN_W-1:0]  k;
    logic [LIMIT_W-1:0] lim;
    case ($urandom_range(0, 5))
      0: k = '0;
      1: k = '1;
      2: k = GAIN_RESET;
      3: k = GAIN_W'($urandom);
      default: k = GAIN_W'($urandom_range(0, 1 << 17));
    endcase
    case ($urandom_range(0, 4))
      0: lim = '0;
      1: lim = '1;
      default: lim = LIMIT_W'($urandom);
    endcase
    write_all(k, lim, pick_needle(), pick_needle(), pick_needle());
  endtask

  // One random request. Full-range samples and tiny elapsed times drive the
  // clamp; small field changes over long intervals give unclamped commands.
  task automatic send_random_item();
    int x, y, z, dt;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        x = $urandom; y = $urandom; z = $urandom;
        dt = $urandom_range(0, 65535);
      end
      3, 4, 5, 6: begin
        x = last_sent[0] + $urandom_range(0, 200) - 100;
        y = last_sent[1] + $urandom_range(0, 200) - 100;
        z = last_sent[2] + $urandom_range(0, 200) - 100;
        dt = $urandom_range(1000, 65535);
      end
      7: begin
        // Zero elapsed time: only the needle term is left.
        x = $urandom; y = $urandom; z = $urandom;
        dt = 0;
      end
      8: begin
        x = $urandom; y = $urandom; z = $urandom;
        dt = $urandom_range(1, 16);
      end
      default: begin
        x = $urandom_range(0, 1) ? 32767 : -32768;
        y = $urandom_range(0, 1) ? 32767 : -32768;
        z = $urandom_range(0, 1) ? 32767 : -32768;
        dt = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535);
      end
    endcase
    send_item(x, y, z, dt);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mag_x = '0;
    mag_y = '0;
    mag_z = '0;
    elapsed_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 38;
    recv_idle_pct = 74;
    hold_off_cycles = 0;
    for (int a = 0; a < NUM_AXES; a++) last_sent[a] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset settings. Zero elapsed time first, then the
    // largest derivatives the sample range allows, in both directions.
    send_item(0, 0, 0, 0);
    send_item(32767, -32768, 1, 1);
    send_item(-32768, 32767, 0, 1);
    send_item(100, -100, 5, 65535);
    // The previous sample is stored even when the elapsed time is zero.
    send_item(5, 5, 5, 0);
    send_item(6, 4, 5, 3);
    send_item(-1, 1, 0, 65535);

    // Unity gain and a matching needle: x lands exactly on the limit and is not
    // capped, y is one above and gets capped, z stays just below.
    wait_idle();
    write_all(GAIN_UNITY, 15'd500, 500, 501, -499);
    send_item(0, 0, 0, 0);
    send_item(0, 0, 0, 0);
    send_item(40, -40, 7, 60000);

    // Zero limit: every nonzero command collapses to zero and sets capped.
    wait_idle();
    write_all(GAIN_RESET, '0, 0, 0, 0);
    send_item(0, 0, 0, 0);
    send_item(1000, -2000, 3, 7);

    // Largest gain against the extreme needles.
    wait_idle();
    write_all('1, '1, 32'h8000_0000, 32'h7FFF_FFFF, -1);
    send_item(0, 0, 0, 0);
    send_item(-32768, 32767, 12, 65535);

    // Writes to the unused indexes must leave the settings alone.
    wait_idle();
    write_all('0, 15'd1234, 1 << 16, -(1 << 16), 0);
    for (int idx = REG_NEEDLE_Z + 1; idx < (1 << CFG_IDX_W); idx++) begin
      cfg_write(CFG_IDX_W'(idx), $urandom);
    end
    send_item(7, 8, 9, 0);
    send_item(-7, -8, -9, 2);

    // Random part. The first three phases idle the sender lightly and the
    // receiver heavily, the next three the other way round, the last three not
    // at all. The last phase opens with a long receiver hold-off while requests
    // keep coming.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      if (phase < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 74;
      end else if (phase < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 0) begin
        write_all(GAIN_RESET, LIMIT_RESET, 0, 0, 0);
      end else begin
        random_config();
      end
      if (phase == RANDOM_PHASES - 1) hold_off_cycles = 500;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random_item();
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bdotmc_pkg.sv
hw/rtl/bdotmc_div.sv
hw/rtl/bdotmc_mul.sv
hw/rtl/bdot_magnetorquer_command.sv
hw/rtl/bdotmc_checker.sv
test/bdotmc_dipole_check.sv
test/tb_top.sv
